FILE: hdl/ordered_list_append_remove_assert.svh
// assertion macros for the ordered list block
// used by the checker module; needs signals named clock and reset in scope
`ifndef ORDERED_LIST_APPEND_REMOVE_ASSERT_SVH
`define ORDERED_LIST_APPEND_REMOVE_ASSERT_SVH

// implication checked in the next cycle, masked while reset is high
`define OLAR_ASSERT_NEXT(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

// same-cycle implication, masked while reset is high
`define OLAR_ASSERT_NOW(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// next-cycle implication that also holds through reset
`define OLAR_ASSERT_ALWAYS_NEXT(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) (pre) |=> (post)) \
      else $error(msg);

`endif

FILE: hdl/olar_pkg.sv
// shared types and constants for the ordered list block
// no dependencies
package olar_pkg;

   localparam int DEPTH = 16;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int VAL_W = 32;

   localparam logic [1:0] FUNC_APPEND = 2'd0;
   localparam logic [1:0] FUNC_REMOVE = 2'd1;
   localparam logic [1:0] FUNC_DUMP   = 2'd2;

   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_FULL     = 2'd1;
   localparam logic [1:0] STAT_NOTFOUND = 2'd2;
   localparam logic [1:0] STAT_EMPTY    = 2'd3;

   typedef struct packed {
      logic [1:0]              func;
      logic signed [VAL_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] item;
      logic                    last;
      logic [1:0]              status;
   } rsp_type;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_APPEND,
      CELL_MATCH,
      CELL_REMOVE,
      CELL_ROTATE
   } cell_op_type;

   // broadcast from the controller to every cell
   typedef struct packed {
      cell_op_type             op;
      logic [CNT_W-1:0]        count;
      logic [CNT_W-1:0]        last_idx;
      logic signed [VAL_W-1:0] wdata;
   } cell_ctl_type;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_MATCH = 3'b010,
      ST_DUMP  = 3'b100
   } state_type;

endpackage

FILE: hdl/ordered_list_append_remove.sv
// Ordered list of up to DEPTH signed words, kept in insertion order.
// Request words (req_valid/req_ready, req_data: func, value):
//   append puts value at the tail, remove deletes the first equal entry
//   and closes the gap, dump streams every entry from head to tail.
// Response words (rsp_valid/rsp_ready, rsp_data: item, last, status):
//   one status word per append or remove, one word per entry on a dump
//   (last marks the tail), one empty-status word for a dump of an empty
//   list; unused func code is taken and gives nothing.
// Timing: append and every empty-list case answer at the accept edge
//   (visible the next cycle, one request per cycle while the output is
//   read); remove is a compare in every cell, then a shift behind the first
//   hit; a dump holds the input until its last word, words one per cycle
//   while the output is read, one rotation of the cell ring per word.
// A new request is taken only when the controller is idle and the output
//   register is empty or being read in that cycle.
// A stalled receiver holds the response word; a dump simply pauses.
// Reset (synchronous) empties the list; cell contents are not cleared and
//   no clearing pass runs.
// Depends on olar_pkg, olar_cell, olar_ctrl.
module ordered_list_append_remove (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  olar_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output olar_pkg::rsp_type rsp_data
);

   olar_pkg::cell_ctl_type            ctl;
   logic signed [olar_pkg::VAL_W-1:0] cell_value [olar_pkg::DEPTH];
   logic signed [olar_pkg::VAL_W-1:0] right_value [olar_pkg::DEPTH];
   logic [olar_pkg::DEPTH:0]          hit;

   assign hit[0] = 1'b0;

   olar_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .head_value (cell_value[0]),
      .any_hit    (hit[olar_pkg::DEPTH]),
      .ctl        (ctl)
   );

   for (genvar i = 0; i < olar_pkg::DEPTH; i++) begin : g_cell
      if (i == olar_pkg::DEPTH - 1) begin : g_end
         assign right_value[i] = cell_value[i];
      end else begin : g_mid
         assign right_value[i] = cell_value[i+1];
      end

      olar_cell u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .cell_idx    (olar_pkg::IDX_W'(i)),
         .right_value (right_value[i]),
         .head_value  (cell_value[0]),
         .hit_in      (hit[i]),
         .hit_out     (hit[i+1]),
         .value       (cell_value[i])
      );
   end

endmodule

FILE: hdl/olar_cell.sv
// one list slot: holds a word, compares it, shifts from its right neighbor
// depends on olar_pkg
module olar_cell (
   input  logic                             clock,
   input  olar_pkg::cell_ctl_type           ctl,
   input  logic [olar_pkg::IDX_W-1:0]       cell_idx,
   input  logic signed [olar_pkg::VAL_W-1:0] right_value,
   input  logic signed [olar_pkg::VAL_W-1:0] head_value,
   input  logic                             hit_in,
   output logic                             hit_out,
   output logic signed [olar_pkg::VAL_W-1:0] value
);

   logic signed [olar_pkg::VAL_W-1:0] value_ff, value_in;
   logic                              match_ff, match_in;
   logic [olar_pkg::CNT_W-1:0]        idx_ext;
   logic                              in_range;

   assign idx_ext  = olar_pkg::CNT_W'(cell_idx);
   assign in_range = idx_ext < ctl.count;
   // a hit at or left of this slot means the slot closes the gap
   assign hit_out  = hit_in | match_ff;
   assign value    = value_ff;

   always_comb begin
      value_in = value_ff;
      match_in = match_ff;
      case (ctl.op)
         olar_pkg::CELL_APPEND: begin
            if (idx_ext == ctl.count) value_in = ctl.wdata;
         end
         olar_pkg::CELL_MATCH: begin
            match_in = in_range && (value_ff == ctl.wdata);
         end
         olar_pkg::CELL_REMOVE: begin
            if (hit_out) value_in = right_value;
         end
         olar_pkg::CELL_ROTATE: begin
            // tail slot takes the head word, the rest move one toward the head
            if (idx_ext == ctl.last_idx) value_in = head_value;
            else value_in = right_value;
         end
         default: begin
            value_in = value_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      match_ff <= match_in;
   end

endmodule

FILE: hdl/olar_ctrl.sv
// sequencer for the ordered list: decodes words, drives the cell row,
// holds the fill count and the output register; depends on olar_pkg
module olar_ctrl (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  olar_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output olar_pkg::rsp_type                 rsp_data,
   input  logic signed [olar_pkg::VAL_W-1:0] head_value,
   input  logic                              any_hit,
   output olar_pkg::cell_ctl_type            ctl
);

   olar_pkg::state_type         state_ff, state_in;
   logic [olar_pkg::CNT_W-1:0]  count_ff, count_in;
   logic [olar_pkg::IDX_W-1:0]  dump_ff, dump_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   olar_pkg::rsp_type           rsp_ff, rsp_in;
   logic                        rsp_free;
   logic                        accept;
   logic                        load;
   logic                        dump_last;
   logic [olar_pkg::CNT_W-1:0]  last_idx;

   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == olar_pkg::ST_IDLE) && rsp_free;
   assign accept    = req_valid && req_ready;
   assign last_idx  = count_ff - olar_pkg::CNT_W'(1);
   assign dump_last = (olar_pkg::CNT_W'(dump_ff) == last_idx);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      dump_in      = dump_ff;
      load         = 1'b0;
      rsp_in       = rsp_ff;
      ctl.op       = olar_pkg::CELL_HOLD;
      ctl.count    = count_ff;
      ctl.last_idx = last_idx;
      ctl.wdata    = req_data.value;
      case (state_ff)
         olar_pkg::ST_IDLE: begin
            if (accept) begin
               rsp_in.item = '0;
               rsp_in.last = 1'b1;
               case (req_data.func)
                  olar_pkg::FUNC_APPEND: begin
                     load = 1'b1;
                     if (count_ff < olar_pkg::CNT_W'(olar_pkg::DEPTH)) begin
                        ctl.op        = olar_pkg::CELL_APPEND;
                        count_in      = count_ff + olar_pkg::CNT_W'(1);
                        rsp_in.status = olar_pkg::STAT_OK;
                     end else begin
                        rsp_in.status = olar_pkg::STAT_FULL;
                     end
                  end
                  olar_pkg::FUNC_REMOVE: begin
                     if (count_ff == '0) begin
                        load          = 1'b1;
                        rsp_in.status = olar_pkg::STAT_EMPTY;
                     end else begin
                        ctl.op   = olar_pkg::CELL_MATCH;
                        state_in = olar_pkg::ST_MATCH;
                     end
                  end
                  olar_pkg::FUNC_DUMP: begin
                     if (count_ff == '0) begin
                        load          = 1'b1;
                        rsp_in.status = olar_pkg::STAT_EMPTY;
                     end else begin
                        dump_in  = '0;
                        state_in = olar_pkg::ST_DUMP;
                     end
                  end
                  default: begin
                     load = 1'b0;
                  end
               endcase
            end
         end
         olar_pkg::ST_MATCH: begin
            // output slot is free here: idle only accepted with it free
            ctl.op      = olar_pkg::CELL_REMOVE;
            load        = 1'b1;
            rsp_in.item = '0;
            rsp_in.last = 1'b1;
            if (any_hit) begin
               count_in      = count_ff - olar_pkg::CNT_W'(1);
               rsp_in.status = olar_pkg::STAT_OK;
            end else begin
               rsp_in.status = olar_pkg::STAT_NOTFOUND;
            end
            state_in = olar_pkg::ST_IDLE;
         end
         olar_pkg::ST_DUMP: begin
            if (rsp_free) begin
               // emit the head, then rotate so the next entry reaches the head
               ctl.op        = olar_pkg::CELL_ROTATE;
               load          = 1'b1;
               rsp_in.item   = head_value;
               rsp_in.last   = dump_last;
               rsp_in.status = olar_pkg::STAT_OK;
               dump_in       = dump_ff + olar_pkg::IDX_W'(1);
               if (dump_last) state_in = olar_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = olar_pkg::ST_IDLE;
         end
      endcase
      if (load) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= olar_pkg::ST_IDLE;
         count_ff     <= '0;
         dump_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         dump_ff      <= dump_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) rsp_ff <= rsp_in;
   end

endmodule

FILE: hdl/olar_checker.sv
// port-level checks for the ordered list block, bound to the top level
// depends on olar_pkg and ordered_list_append_remove_assert.svh
`include "ordered_list_append_remove_assert.svh"

module olar_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input olar_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input olar_pkg::rsp_type rsp_data
);

   logic append_taken;
   assign append_taken = !reset && req_valid && req_ready &&
                         (req_data.func == olar_pkg::FUNC_APPEND);

   `OLAR_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "stalled response word changed")
   `OLAR_ASSERT_NOW(a_status_word, rsp_valid && (rsp_data.status != olar_pkg::STAT_OK), (rsp_data.item == '0) && rsp_data.last, "non-ok word must carry zero item and last")
   `OLAR_ASSERT_NOW(a_slot_free, req_ready, !rsp_valid || rsp_ready, "request taken while output register is held")
   `OLAR_ASSERT_NEXT(a_append_answer, append_taken, rsp_valid, "append word gave no status word next cycle")
   `OLAR_ASSERT_ALWAYS_NEXT(a_reset_quiet, reset, !rsp_valid, "response valid right after reset")

endmodule

bind ordered_list_append_remove olar_checker u_checker (.*);
